@@ src/qphp_pkg.sv @@
// Shared types and constants for the QR part header parser.
`default_nettype none
package qphp_pkg;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;
  localparam int COUNT_W    = 11;

  // characters
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_J      = 8'h4A;
  localparam logic [7:0] CH_U      = 8'h55;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  // header character positions
  localparam logic [3:0] POS_MAGIC_B   = 4'd0;
  localparam logic [3:0] POS_MAGIC_D   = 4'd1;
  localparam logic [3:0] POS_ENCODING  = 4'd2;
  localparam logic [3:0] POS_FILE_TYPE = 4'd3;
  localparam logic [3:0] POS_TOTAL_HI  = 4'd4;
  localparam logic [3:0] POS_TOTAL_LO  = 4'd5;
  localparam logic [3:0] POS_INDEX_HI  = 4'd6;
  localparam logic [3:0] POS_INDEX_LO  = 4'd7;
  localparam logic [3:0] POS_PAYLOAD   = 4'd8;

  typedef enum logic [1:0] {
    ENC_HEX    = 2'd0,
    ENC_BASE32 = 2'd1,
    ENC_ZLIB   = 2'd2
  } enc_t;

  typedef enum logic [1:0] {
    FT_PSBT = 2'd0,
    FT_TXN  = 2'd1,
    FT_JSON = 2'd2,
    FT_TEXT = 2'd3
  } ftype_t;

  typedef enum logic [1:0] {
    RT_HEADER = 2'd0,
    RT_BYTE   = 2'd1,
    RT_RAW    = 2'd2,
    RT_END    = 2'd3
  } res_kind_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_MAGIC    = 4'd1,
    ST_ENCODING = 4'd2,
    ST_TYPE     = 4'd3,
    ST_TOTAL    = 4'd4,
    ST_INDEX    = 4'd5,
    ST_SHORT    = 4'd6,
    ST_HEX      = 4'd7,
    ST_ODD      = 4'd8
  } status_t;

  typedef struct packed {
    res_kind_t            rtype;
    logic [1:0]           encoding;
    logic [1:0]           ftype;
    logic [COUNT_W-1:0]   total_parts;
    logic [COUNT_W-1:0]   part_idx;
    logic [7:0]           data_byte;
    status_t              status;
    logic                 end_flag;
  } res_t;

endpackage
`default_nettype wire

@@ src/qr_part_header_parser_top.sv @@
// Top level of the QR part header parser: input register, parse logic, result queue.
// A word taken into the input register is parsed there and its results go into the queue.
// Throughput: one input word per cycle while the queue has room; a header or payload byte on
// the final character pushes two results, and the four-entry result queue absorbs them as input flows.
// A stall on the output side holds input once the queue lacks room for two results.
// Reset (rst_n low, synchronous) clears the parse state, the input valid flag and the queue.
`default_nettype none
module qr_part_header_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [1:0] encoding, [3:2] ftype, [14:4] total_parts,
                                       // [25:15] part_idx, [33:26] data_byte, [37:34] status
  output logic [1:0]       out_tuser,  // [1:0] result_type
  output logic             out_tlast   // end_flag
);
  import qphp_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // input register
  logic       in_v_r;
  logic [7:0] in_char_r;
  logic       in_last_r;

  // parse state
  logic [3:0]         pos_r, pos_nxt;
  logic [5:0]         first_r, first_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic [1:0]         enc_r, enc_nxt;
  logic [1:0]         ftype_r, ftype_nxt;
  status_t            err_r, err_nxt;
  logic [3:0]         nib_r, nib_nxt;
  logic               phase_r, phase_nxt;

  // result queue
  res_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;

  logic       fire, pop;
  logic [1:0] n_push;
  res_t       slot0, slot1, item_res, end_res;
  logic       item_emit;

  logic [7:0]         uc;
  logic               b36_ok, hex_ok;
  logic [5:0]         b36_val;
  logic [3:0]         hex_val;
  logic [COUNT_W-1:0] pair_val;
  status_t            end_st;

  assign pop       = out_tvalid && out_tready;
  assign fire      = in_v_r && ((cnt_r - QCNT_W'(pop)) <= QCNT_W'(QDEPTH - 2));
  assign in_tready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // character classes
  always_comb begin
    uc = (in_char_r >= CH_LA && in_char_r <= CH_LZ) ? in_char_r - CASE_GAP : in_char_r;
    b36_ok  = 1'b1;
    b36_val = '0;
    if (uc >= CH_ZERO && uc <= CH_NINE) begin
      b36_val = 6'(uc - CH_ZERO);
    end else if (uc >= CH_UA && uc <= CH_UZ) begin
      b36_val = 6'(uc - CH_UA + 8'd10);
    end else begin
      b36_ok = 1'b0;
    end
    hex_ok  = 1'b1;
    hex_val = '0;
    if (uc >= CH_ZERO && uc <= CH_NINE) begin
      hex_val = 4'(uc - CH_ZERO);
    end else if (uc >= CH_UA && uc <= CH_UF) begin
      hex_val = 4'(uc - CH_UA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
    pair_val = COUNT_W'({first_r, 5'b0}) + COUNT_W'({first_r, 2'b0}) + COUNT_W'(b36_val);
  end

  // parse step
  always_comb begin
    pos_nxt   = pos_r;
    first_nxt = first_r;
    total_nxt = total_r;
    enc_nxt   = enc_r;
    ftype_nxt = ftype_r;
    err_nxt   = err_r;
    nib_nxt   = nib_r;
    phase_nxt = phase_r;
    item_emit = 1'b0;
    item_res  = '0;
    end_res   = '0;
    end_st    = ST_OK;

    if (err_r == ST_OK) begin
      unique case (pos_r)
        POS_MAGIC_B: begin
          if (in_char_r != CH_B) err_nxt = ST_MAGIC;
        end
        POS_MAGIC_D: begin
          if (in_char_r != CH_DOLLAR) err_nxt = ST_MAGIC;
        end
        POS_ENCODING: begin
          if (uc == CH_H) enc_nxt = ENC_HEX;
          else if (uc == CH_TWO) enc_nxt = ENC_BASE32;
          else if (uc == CH_Z) enc_nxt = ENC_ZLIB;
          else err_nxt = ST_ENCODING;
        end
        POS_FILE_TYPE: begin
          if (uc == CH_P) ftype_nxt = FT_PSBT;
          else if (uc == CH_T) ftype_nxt = FT_TXN;
          else if (uc == CH_J) ftype_nxt = FT_JSON;
          else if (uc == CH_U) ftype_nxt = FT_TEXT;
          else err_nxt = ST_TYPE;
        end
        POS_TOTAL_HI, POS_INDEX_HI: begin
          if (!b36_ok) err_nxt = (pos_r == POS_TOTAL_HI) ? ST_TOTAL : ST_INDEX;
          else first_nxt = b36_val;
        end
        POS_TOTAL_LO: begin
          if (!b36_ok || pair_val == '0) err_nxt = ST_TOTAL;
          else total_nxt = pair_val;
        end
        POS_INDEX_LO: begin
          if (!b36_ok || pair_val >= total_r) begin
            err_nxt = ST_INDEX;
          end else begin
            item_emit            = 1'b1;
            item_res.rtype       = RT_HEADER;
            item_res.encoding    = enc_r;
            item_res.ftype       = ftype_r;
            item_res.total_parts = total_r;
            item_res.part_idx    = pair_val;
            item_res.status      = ST_OK;
          end
        end
        default: begin
          if (enc_r == ENC_HEX) begin
            if (!hex_ok) begin
              err_nxt = ST_HEX;
            end else if (!phase_r) begin
              nib_nxt   = hex_val;
              phase_nxt = 1'b1;
            end else begin
              item_emit          = 1'b1;
              item_res.rtype     = RT_BYTE;
              item_res.data_byte = {nib_r, hex_val};
              item_res.status    = ST_OK;
              phase_nxt          = 1'b0;
            end
          end else begin
            item_emit          = 1'b1;
            item_res.rtype     = RT_RAW;
            item_res.data_byte = in_char_r;
            item_res.status    = ST_OK;
          end
        end
      endcase
      if (pos_r < POS_PAYLOAD) pos_nxt = pos_r + 4'd1;
    end

    if (in_last_r) begin
      end_st = err_nxt;
      if (err_nxt == ST_OK) begin
        if (pos_nxt < POS_PAYLOAD) end_st = ST_SHORT;
        else if (enc_nxt == ENC_HEX && phase_nxt) end_st = ST_ODD;
      end
      end_res.rtype    = RT_END;
      end_res.status   = end_st;
      end_res.end_flag = 1'b1;
      pos_nxt   = '0;
      first_nxt = '0;
      total_nxt = '0;
      enc_nxt   = '0;
      ftype_nxt = '0;
      err_nxt   = ST_OK;
      nib_nxt   = '0;
      phase_nxt = 1'b0;
    end

    slot0  = item_emit ? item_res : end_res;
    slot1  = end_res;
    n_push = 2'(item_emit) + 2'(in_last_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      first_r <= '0;
      total_r <= '0;
      enc_r   <= '0;
      ftype_r <= '0;
      err_r   <= ST_OK;
      nib_r   <= '0;
      phase_r <= 1'b0;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      first_r <= first_nxt;
      total_r <= total_nxt;
      enc_r   <= enc_nxt;
      ftype_r <= ftype_nxt;
      err_r   <= err_nxt;
      nib_r   <= nib_nxt;
      phase_r <= phase_nxt;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (fire && n_push != 2'd0) begin
      q_r[wr_r] <= slot0;
      if (n_push == 2'd2) q_r[wr_r + QPTR_W'(1)] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (fire) wr_r <= wr_r + QPTR_W'(n_push);
      if (pop) rd_r <= rd_r + QPTR_W'(1);
      cnt_r <= cnt_r + (fire ? QCNT_W'(n_push) : QCNT_W'(0)) - QCNT_W'(pop);
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tuser  = q_r[rd_r].rtype;
  assign out_tlast  = q_r[rd_r].end_flag;
  assign out_tdata  = {2'b00, q_r[rd_r].status, q_r[rd_r].data_byte, q_r[rd_r].part_idx,
                       q_r[rd_r].total_parts, q_r[rd_r].ftype, q_r[rd_r].encoding};

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue count over depth");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_PAYLOAD)
    else $error("header position past payload");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_last_r |=> pos_r == POS_MAGIC_B && err_r == ST_OK && !phase_r)
    else $error("parse state not cleared after final character");

  a_hdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item_emit && item_res.rtype == RT_HEADER |-> pos_r == POS_INDEX_LO)
    else $error("header result outside index position");
`endif

endmodule
`default_nettype wire
